[rtl/block_patch_sum_trigger_defines.svh]
// ---------------------------------------------------------------------------
// Patch sum trigger assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BLOCK_PATCH_SUM_TRIGGER_DEFINES_SVH
`define BLOCK_PATCH_SUM_TRIGGER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPST_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BPST_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPST_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define BPST_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

[rtl/bpst_pkg.sv]
// ---------------------------------------------------------------------------
// Patch sum trigger package
// Item types, register codes and fixed widths shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpst_pkg;

	localparam int ADC_FIELD_W = 12;
	localparam int SUM_W       = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [SUM_W-1:0] SUM_MAX  = '1;
	localparam logic [4:0]       EDGE_MAX = 5'd16;

	// register reset values
	localparam logic [6:0]  NUM_COLS_RST  = 7'd48;
	localparam logic [6:0]  ROW_MIN_RST   = 7'd0;
	localparam logic [7:0]  ROW_MAX_RST   = 8'd0;
	localparam logic [4:0]  PATCH_SIZE_RST = 5'd2;
	localparam logic [19:0] THRESHOLD_RST = 20'd0;
	localparam logic [31:0] BITMASK_RST   = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_COLS   = 3'd0,
		REG_ROW_MIN    = 3'd1,
		REG_ROW_MAX    = 3'd2,
		REG_PATCH_SIZE = 3'd3,
		REG_THRESHOLD  = 3'd4,
		REG_BITMASK    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [ADC_FIELD_W-1:0] cell_adc;
		logic                   frame_start;
	} cell_t;

	typedef struct packed {
		logic [5:0]  patch_col;
		logic [6:0]  patch_row;
		logic [4:0]  patch_edge;
		logic [19:0] patch_sum;
		logic [31:0] patch_bits;
	} patch_t;

	// one cell's job from the position tracker to the accumulator
	typedef struct packed {
		logic                   mem_en;   // cell lies in the tiled area
		logic                   first;    // top-left cell of its patch
		logic                   geo_ok;   // bottom-right cell of a patch inside the bounds
		logic [5:0]             left;
		logic [6:0]             top;
		logic [4:0]             edge_len;
		logic [ADC_FIELD_W-1:0] adc;
	} op_t;

endpackage

[rtl/bpst_ctrl.sv]
// ---------------------------------------------------------------------------
// Patch sum trigger position tracker
// Follows the raster position and the place of each cell inside its patch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpst_ctrl #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 128,
	parameter int ADC_BITS = 12,
	localparam int IDX_W = $clog2(MAX_COLS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  bpst_pkg::cell_t cell_item,
	input  logic [6:0]      num_cols,
	input  logic [6:0]      row_min,
	input  logic [7:0]      row_max,
	input  logic [4:0]      patch_size,
	output bpst_pkg::op_t   op,
	output logic [IDX_W-1:0] idx
);
	import bpst_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CLW0  = $clog2(MAX_COLS + 1);
	localparam int CLW   = (CLW0 > 7) ? CLW0 : 7;
	localparam int RCW   = ((RW > 8) ? RW : 8) + 2;
	localparam int CCW   = CLW + 2;
	localparam int ADC_W = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;

	logic [IDX_W-1:0] col_q, col_e, col_n;
	logic [RW-1:0]    row_q, row_e, row_n;
	logic [3:0]       cip_q, cip_e, cip_n;
	logic [3:0]       rip_q, rip_e, rip_n;
	logic [IDX_W-1:0] pidx_q, pidx_e, pidx_n;
	logic             done_q, done_e, done_n;
	logic [CLW-1:0]   cols_e;
	logic [4:0]       ps_e;
	logic [RCW-1:0]   top_full;
	logic [CCW-1:0]   left_full;
	logic             geo;

	// clamped register values
	always_comb begin
		if (num_cols == 7'd0)
			cols_e = CLW'(1);
		else if (CLW'(num_cols) > CLW'(MAX_COLS))
			cols_e = CLW'(MAX_COLS);
		else
			cols_e = CLW'(num_cols);
		if (patch_size == 5'd0)
			ps_e = 5'd1;
		else if (patch_size > EDGE_MAX)
			ps_e = EDGE_MAX;
		else
			ps_e = patch_size;
	end

	// frame start restarts the position before the cell is used
	always_comb begin
		col_e  = cell_item.frame_start ? '0 : col_q;
		row_e  = cell_item.frame_start ? '0 : row_q;
		cip_e  = cell_item.frame_start ? '0 : cip_q;
		rip_e  = cell_item.frame_start ? '0 : rip_q;
		pidx_e = cell_item.frame_start ? '0 : pidx_q;
		done_e = cell_item.frame_start ? 1'b0 : done_q;
	end

	// patch geometry of this cell
	always_comb begin
		top_full  = RCW'(row_e) - RCW'(rip_e);
		left_full = CCW'(col_e) - CCW'(cip_e);
		geo = (RCW'(row_e) >= RCW'(rip_e) + RCW'(row_min)) &&
		      (CCW'(col_e) >= CCW'(cip_e)) &&
		      (RCW'(row_e) + RCW'(ps_e) < RCW'(row_max) + RCW'(rip_e)) &&
		      (CCW'(col_e) + CCW'(ps_e) < CCW'(cols_e) + CCW'(cip_e));
	end

	always_comb begin
		op.mem_en   = !done_e && (RCW'(row_e) >= RCW'(row_min));
		op.first    = (cip_e == 4'd0) && (rip_e == 4'd0);
		op.geo_ok   = ({1'b0, cip_e} == ps_e - 5'd1) && ({1'b0, rip_e} == ps_e - 5'd1) && geo;
		op.left     = left_full[5:0];
		op.top      = top_full[6:0];
		op.edge_len = ps_e;
		op.adc      = ADC_FIELD_W'(cell_item.cell_adc[ADC_W-1:0]);
		idx         = pidx_e;
	end

	// step to the next raster position
	always_comb begin
		col_n  = col_e;
		row_n  = row_e;
		cip_n  = cip_e;
		rip_n  = rip_e;
		pidx_n = pidx_e;
		done_n = done_e;
		if (!done_e) begin
			if (CCW'(col_e) + CCW'(1) >= CCW'(cols_e)) begin
				col_n  = '0;
				cip_n  = '0;
				pidx_n = '0;
				if (RCW'(row_e) + RCW'(1) >= RCW'(MAX_ROWS)) begin
					done_n = 1'b1;
				end else begin
					row_n = row_e + RW'(1);
					if (RCW'(row_e) + RCW'(1) <= RCW'(row_min))
						rip_n = '0;
					else if (5'({1'b0, rip_e}) + 5'd1 >= ps_e)
						rip_n = '0;
					else
						rip_n = rip_e + 4'd1;
				end
			end else begin
				col_n = col_e + IDX_W'(1);
				if (5'({1'b0, cip_e}) + 5'd1 >= ps_e) begin
					cip_n  = '0;
					pidx_n = pidx_e + IDX_W'(1);
				end else begin
					cip_n = cip_e + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cip_q  <= '0;
			rip_q  <= '0;
			pidx_q <= '0;
			done_q <= 1'b0;
		end else if (take) begin
			col_q  <= col_n;
			row_q  <= row_n;
			cip_q  <= cip_n;
			rip_q  <= rip_n;
			pidx_q <= pidx_n;
			done_q <= done_n;
		end
	end

endmodule

[rtl/bpst_accum.sv]
// ---------------------------------------------------------------------------
// Patch sum trigger accumulator
// Column sum memory with read, add, saturate and write back, plus the
// threshold test on finished patches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_patch_sum_trigger_defines.svh"

module bpst_accum #(
	parameter int MAX_COLS = 64,
	localparam int IDX_W = $clog2(MAX_COLS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  bpst_pkg::op_t    op,
	input  logic [IDX_W-1:0] idx,
	input  logic [19:0]      threshold,
	input  logic [31:0]      bitmask,
	input  logic             out_busy,
	output logic             hold,
	output logic             res_load,
	output bpst_pkg::patch_t res
);
	import bpst_pkg::*;

	logic [SUM_W-1:0] mem [MAX_COLS];
	logic [MAX_COLS-1:0] vld_q;

	logic             valid_s1;
	op_t              op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SUM_W-1:0] rd_s1;
	logic             vld_s1;
	logic             fwd_s1;
	logic [SUM_W-1:0] fwd_data_s1;

	logic [SUM_W-1:0] base;
	logic [SUM_W:0]   sum_w;
	logic [SUM_W-1:0] sum;
	logic             rep;
	logic             wr_en;

	// old sum: zero for a patch's first cell, else forwarded write, stored entry, or zero when never written
	always_comb begin
		if (op_s1.first)
			base = '0;
		else if (fwd_s1)
			base = fwd_data_s1;
		else if (vld_s1)
			base = rd_s1;
		else
			base = '0;
		sum_w = {1'b0, base} + (SUM_W + 1)'(op_s1.adc);
		sum   = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
		rep   = op_s1.geo_ok && (sum > threshold);
	end

	// the stage waits only for a report that cannot enter the output register
	always_comb begin
		hold     = valid_s1 && rep && out_busy;
		wr_en    = valid_s1 && !hold;
		res_load = wr_en && rep;
		res.patch_col  = op_s1.left;
		res.patch_row  = op_s1.top;
		res.patch_edge = op_s1.edge_len;
		res.patch_sum  = sum;
		res.patch_bits = bitmask;
	end

	// column sum memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_s1] <= sum;
		if (take)
			rd_s1 <= mem[idx];
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1       <= op;
			idx_s1      <= idx;
			vld_s1      <= vld_q[idx];
			fwd_s1      <= wr_en && (idx_s1 == idx);
			fwd_data_s1 <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (take)
				valid_s1 <= op.mem_en;
			else if (wr_en)
				valid_s1 <= 1'b0;
			if (wr_en)
				vld_q[idx_s1] <= 1'b1;
		end
	end

	`BPST_ASSERT_IMP(a_no_take_on_hold, clk, arst_n, take, !hold, "item taken while stage held")
	`BPST_ASSERT_NXT(a_hold_keeps_idx, clk, arst_n, hold && !take, valid_s1 && $stable(idx_s1), "held stage lost its entry")
	`BPST_ASSERT_NXT(a_write_marks_valid, clk, arst_n, wr_en, vld_q[$past(idx_s1)], "written entry not marked valid")

endmodule

[rtl/bpst_outreg.sv]
// ---------------------------------------------------------------------------
// Patch sum trigger output register
// Holds one reported patch until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpst_outreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bpst_pkg::patch_t res,
	input  logic             patch_stall,
	output logic             patch_valid,
	output bpst_pkg::patch_t patch,
	output logic             busy
);
	import bpst_pkg::*;

	logic   valid_q;
	patch_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!patch_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= res;
	end

	assign busy        = valid_q && patch_stall;
	assign patch_valid = valid_q;
	assign patch       = data_q;

endmodule

[rtl/block_patch_sum_trigger.sv]
// ---------------------------------------------------------------------------
// Patch sum threshold trigger
// Sums ADC cells over square patches of a raster-scanned grid, one running
// sum per patch column, and reports patches above threshold in scan order.
//
//   channel  dir  handshake                 item
//   cell     in   cell_valid / cell_stall   cell_adc, frame_start
//   patch    out  patch_valid / patch_stall patch origin, edge, sum, bits
//   cfg      in   cfg_we                    cfg_index, cfg_data
//
// One cell per clock while cell_stall is low; a report passes the accumulator
// stage and then the output register. The rate is set by the column sum memory,
// read as a cell is taken and written back from the accumulator stage, with a
// forward path for back-to-back cells of the same patch column. Reset clears
// position, valid bits and the output register; no clearing pass. cell_stall
// rises only while a report waits on a full, stalled output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_patch_sum_trigger #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 128,
	parameter int ADC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bpst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpst_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  bpst_pkg::cell_t                     cell_item,
	output logic                                patch_valid,
	input  logic                                patch_stall,
	output bpst_pkg::patch_t                    patch
);
	import bpst_pkg::*;

	localparam int IDX_W = $clog2(MAX_COLS);

	logic [6:0]  num_cols_q;
	logic [6:0]  row_min_q;
	logic [7:0]  row_max_q;
	logic [4:0]  patch_size_q;
	logic [19:0] threshold_q;
	logic [31:0] bitmask_q;

	logic             take;
	op_t              op;
	logic [IDX_W-1:0] idx;
	logic             hold;
	logic             res_load;
	patch_t           res;
	logic             out_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q   <= NUM_COLS_RST;
			row_min_q    <= ROW_MIN_RST;
			row_max_q    <= ROW_MAX_RST;
			patch_size_q <= PATCH_SIZE_RST;
			threshold_q  <= THRESHOLD_RST;
			bitmask_q    <= BITMASK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_COLS:   num_cols_q   <= cfg_data[6:0];
				REG_ROW_MIN:    row_min_q    <= cfg_data[6:0];
				REG_ROW_MAX:    row_max_q    <= cfg_data[7:0];
				REG_PATCH_SIZE: patch_size_q <= cfg_data[4:0];
				REG_THRESHOLD:  threshold_q  <= cfg_data[19:0];
				REG_BITMASK:    bitmask_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cell_stall = hold;
	assign take       = cell_valid && !hold;

	bpst_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.ADC_BITS (ADC_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.cell_item  (cell_item),
		.num_cols   (num_cols_q),
		.row_min    (row_min_q),
		.row_max    (row_max_q),
		.patch_size (patch_size_q),
		.op         (op),
		.idx        (idx)
	);

	bpst_accum #(
		.MAX_COLS (MAX_COLS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (op),
		.idx       (idx),
		.threshold (threshold_q),
		.bitmask   (bitmask_q),
		.out_busy  (out_busy),
		.hold      (hold),
		.res_load  (res_load),
		.res       (res)
	);

	bpst_outreg u_outreg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_load),
		.res         (res),
		.patch_stall (patch_stall),
		.patch_valid (patch_valid),
		.patch       (patch),
		.busy        (out_busy)
	);

endmodule

[verif/block_patch_sum_trigger_tb.sv]
// ---------------------------------------------------------------------------
// Patch sum trigger testbench
// Streams raster-scanned cell grids into the block under a range of register
// settings and idle patterns. A scoreboard tracks the grid position and the
// per-column patch sums, and compares every patch report against its own
// prediction, in order and field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class patch_scoreboard;
	// register copies, raw as written
	logic [6:0]  num_cols;
	logic [6:0]  row_min;
	logic [7:0]  row_max;
	logic [4:0]  patch_size;
	logic [19:0] threshold;
	logic [31:0] trig_bits;

	// grid position and running sums
	logic [19:0] col_sum [64];
	logic [5:0]  cur_col;
	logic [6:0]  cur_row;
	logic [3:0]  col_in_patch;
	logic [3:0]  row_in_patch;
	logic [5:0]  patch_index;
	bit          grid_full;

	bpst_pkg::patch_t expected_patches [$];
	int errors;
	int cells_seen;
	int patches_seen;

	function new();
		num_cols   = bpst_pkg::NUM_COLS_RST;
		row_min    = bpst_pkg::ROW_MIN_RST;
		row_max    = bpst_pkg::ROW_MAX_RST;
		patch_size = bpst_pkg::PATCH_SIZE_RST;
		threshold  = bpst_pkg::THRESHOLD_RST;
		trig_bits  = bpst_pkg::BITMASK_RST;
		foreach (col_sum[i])
			col_sum[i] = '0;
		restart_frame();
	endfunction

	function void restart_frame();
		cur_col      = '0;
		cur_row      = '0;
		col_in_patch = '0;
		row_in_patch = '0;
		patch_index  = '0;
		grid_full    = 1'b0;
	endfunction

	function void write_reg(logic [bpst_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			bpst_pkg::REG_NUM_COLS:   num_cols   = data[6:0];
			bpst_pkg::REG_ROW_MIN:    row_min    = data[6:0];
			bpst_pkg::REG_ROW_MAX:    row_max    = data[7:0];
			bpst_pkg::REG_PATCH_SIZE: patch_size = data[4:0];
			bpst_pkg::REG_THRESHOLD:  threshold  = data[19:0];
			bpst_pkg::REG_BITMASK:    trig_bits  = data;
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_patches.size();
	endfunction

	// one accepted cell: update sums and position, queue a report if due
	function void note_cell(bpst_pkg::cell_t c);
		int cols;
		int ps;
		int sum;
		int top;
		int left;
		bpst_pkg::patch_t rep;
		cols = (num_cols < 1) ? 1 : (num_cols > 64) ? 64 : int'(num_cols);
		ps   = (patch_size < 1) ? 1 : (patch_size > 16) ? 16 : int'(patch_size);
		cells_seen++;
		if (c.frame_start)
			restart_frame();
		if (grid_full)
			return;

		if (cur_row >= row_min) begin
			// top-left cell of a patch loads, the rest accumulate
			if (col_in_patch == 0 && row_in_patch == 0) begin
				sum = int'(c.cell_adc);
			end else begin
				sum = int'(col_sum[patch_index]) + int'(c.cell_adc);
				if (sum > int'(bpst_pkg::SUM_MAX))
					sum = int'(bpst_pkg::SUM_MAX);
			end
			col_sum[patch_index] = sum[19:0];

			if (int'(col_in_patch) == ps - 1 && int'(row_in_patch) == ps - 1) begin
				top  = int'(cur_row) - int'(row_in_patch);
				left = int'(cur_col) - int'(col_in_patch);
				if (top >= int'(row_min) && left >= 0 && top + ps < int'(row_max) &&
						left + ps < cols && sum > int'(threshold)) begin
					rep.patch_col  = left[5:0];
					rep.patch_row  = top[6:0];
					rep.patch_edge = ps[4:0];
					rep.patch_sum  = sum[19:0];
					rep.patch_bits = trig_bits;
					expected_patches.insert(expected_patches.size(), rep);
				end
			end
		end

		// step to the next cell position
		if (int'(cur_col) + 1 >= cols) begin
			cur_col      = '0;
			col_in_patch = '0;
			patch_index  = '0;
			if (int'(cur_row) + 1 >= 128) begin
				grid_full = 1'b1;
			end else begin
				cur_row++;
				if (cur_row <= row_min)
					row_in_patch = '0;
				else if (int'(row_in_patch) + 1 >= ps)
					row_in_patch = '0;
				else
					row_in_patch++;
			end
		end else begin
			cur_col++;
			if (int'(col_in_patch) + 1 >= ps) begin
				col_in_patch = '0;
				patch_index++;
			end else begin
				col_in_patch++;
			end
		end
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// one accepted report against the oldest prediction
	function void check_patch(bpst_pkg::patch_t p);
		bpst_pkg::patch_t want;
		patches_seen++;
		if (expected_patches.size() == 0) begin
			$display("%0t: report with none expected, expected nothing, got col %0d row %0d sum %0d",
				$time, p.patch_col, p.patch_row, p.patch_sum);
			errors++;
			return;
		end
		want = expected_patches.pop_front();
		compare_field("patch_col", want.patch_col, p.patch_col);
		compare_field("patch_row", want.patch_row, p.patch_row);
		compare_field("patch_edge", want.patch_edge, p.patch_edge);
		compare_field("patch_sum", want.patch_sum, p.patch_sum);
		compare_field("patch_bits", want.patch_bits, p.patch_bits);
	endfunction
endclass

module block_patch_sum_trigger_tb;
	import bpst_pkg::*;

	localparam int RANDOM_ITEMS  = 1650;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_CELLS     = 400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = REG_BITMASK + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = REG_BITMASK + 3'd2;

	typedef enum int {PH_FRAME, PH_CONTINUE, PH_OVERRUN, PH_EXTREME, PH_NOISE} phase_kind_t;
	typedef enum int {MIX_FULL, MIX_MAX, MIX_LOW, MIX_EDGES} adc_mix_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_NUM_COLS;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  cell_valid  = 1'b0;
	logic                  cell_stall;
	cell_t                 cell_in     = '0;
	logic                  patch_valid;
	logic                  patch_stall = 1'b0;
	patch_t                patch_out;

	patch_scoreboard sb = new();

	int n_sent     = 0;
	int n_settings = 0;
	int src_idle   = 25;
	int sink_stall = 50;
	int quiet      = 0;

	// ports in declaration order
	block_patch_sum_trigger dut (
		clk, arst_n, cfg_we, cfg_index, cfg_data,
		cell_valid, cell_stall, cell_in,
		patch_valid, patch_stall, patch_out
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk)
		patch_stall = ($urandom_range(99) < sink_stall);

	// sample handshakes and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (cell_valid && !cell_stall)
				sb.note_cell(cell_in);
			if (patch_valid && !patch_stall)
				sb.check_patch(patch_out);
			if ((cell_valid && !cell_stall) || (patch_valid && !patch_stall))
				quiet = 0;
			else
				quiet++;
		end
	end

	// watchdog on stretches with no item moving
	initial begin
		wait (arst_n);
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// present one cell and hold it until taken; called and left at a falling edge
	task automatic send_cell(input int adc, input bit fs);
		src_idle   = (n_sent < RANDOM_ITEMS / 3) ? 25 : (n_sent < 2 * RANDOM_ITEMS / 3) ? 50 : 0;
		sink_stall = (n_sent < RANDOM_ITEMS / 3) ? 50 : (n_sent < 2 * RANDOM_ITEMS / 3) ? 25 : 0;
		cell_valid = 1'b1;
		cell_in    = '{cell_adc: adc[ADC_FIELD_W-1:0], frame_start: fs};
		do
			@(posedge clk);
		while (cell_stall);
		n_sent++;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			cell_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// let every report out, then write all registers; spare indexes optional
	task automatic apply_config(input int cols, input int rmin, input int rmax, input int ps,
			input int thr, input logic [31:0] mask, input bit spare);
		cfg_reg_t    regs [6]  = '{REG_NUM_COLS, REG_ROW_MIN, REG_ROW_MAX,
			REG_PATCH_SIZE, REG_THRESHOLD, REG_BITMASK};
		logic [31:0] keep [6]  = '{32'h7F, 32'h7F, 32'hFF, 32'h1F, 32'hF_FFFF, 32'hFFFF_FFFF};
		logic [31:0] vals [6];
		vals = '{cols, rmin, rmax, ps, thr, mask};
		cell_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		foreach (regs[i]) begin
			cfg_we    = 1'b1;
			cfg_index = regs[i];
			// junk above the field width must be dropped
			cfg_data  = (vals[i] & keep[i]) | ($urandom & ~keep[i]);
			@(negedge clk);
		end
		if (spare) begin
			cfg_index = REG_SPARE_0;
			cfg_data  = $urandom;
			@(negedge clk);
			cfg_index = REG_SPARE_1;
			cfg_data  = $urandom;
			@(negedge clk);
		end
		cfg_we = 1'b0;
		n_settings++;
	endtask

	initial begin
		phase_kind_t kind;
		adc_mix_t    adc_mode;
		int          phase_no;
		int          target;
		int          r;
		int          cols;
		int          rmin;
		int          rmax;
		int          ps;
		int          thr;
		int          rows;
		int          pr;
		int          cells;
		int          restart_at;
		int          fs_pct;
		int          adc;
		int          ec;
		int          amax;
		bit          with_start;
		bit          fs;
		logic [31:0] mask;
		int          col_ext  [4] = '{0, 1, 64, 127};
		int          rmin_ext [2] = '{0, 127};
		int          rmax_ext [3] = '{0, 128, 255};
		int          ps_ext   [4] = '{0, 1, 16, 31};
		int          thr_ext  [2] = '{0, 1048575};
		logic [31:0] mask_ext [2] = '{32'h0, 32'hFFFF_FFFF};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: row limit 0, nothing may report
		send_cell(4095, 1'b1);
		send_cell(0, 1'b0);
		send_cell(4095, 1'b0);

		// single-cell patches, edge values of the ADC and threshold, restart mid-frame
		apply_config(3, 0, 3, 1, 4094, 32'hFFFF_FFFF, 1'b0);
		send_cell(4095, 1'b1);
		send_cell(4095, 1'b0);
		send_cell(4095, 1'b0);
		send_cell(0, 1'b0);
		send_cell(4094, 1'b0);
		send_cell(4095, 1'b0);
		send_cell(4095, 1'b0);
		send_cell(4095, 1'b1);

		// first row lies above row_min and is skipped; spare indexes are ignored
		apply_config(3, 1, 5, 2, 0, 32'hA5A5_5A5A, 1'b1);
		for (int k = 0; k < 12; k++)
			send_cell((k < 3) ? 4095 : $urandom_range(4095), k == 0);

		target   = n_sent + RANDOM_ITEMS;
		phase_no = 0;
		while (n_sent < target) begin
			if (phase_no == 1) begin
				kind = PH_OVERRUN;
			end else if (phase_no == 3) begin
				kind = PH_EXTREME;
			end else begin
				r = $urandom_range(99);
				kind = (r < 60) ? PH_FRAME : (r < 76) ? PH_CONTINUE : (r < 86) ? PH_EXTREME :
					(r < 94) ? PH_NOISE : PH_OVERRUN;
			end
			adc_mode   = adc_mix_t'($urandom_range(3));
			amax       = (adc_mode == MIX_LOW) ? 15 : 4095;
			mask       = $urandom;
			with_start = 1'b1;
			fs_pct     = 0;
			restart_at = -1;

			case (kind)
				PH_FRAME, PH_CONTINUE: begin
					r  = $urandom_range(99);
					ps = (r < 70) ? $urandom_range(1, 3) : (r < 90) ? $urandom_range(4, 8) :
						$urandom_range(9, 16);
					if (ps > 8) begin
						cols = ps + 1 + $urandom_range(2);
						pr   = 1;
					end else if (ps <= 2 && $urandom_range(9) == 0) begin
						// a wide grid now and then
						cols = $urandom_range(40, 64);
						pr   = 1;
					end else begin
						cols = ps * $urandom_range(1, 3) + $urandom_range(2);
						pr   = $urandom_range(1, 3);
					end
					rmin  = $urandom_range(3);
					rows  = rmin + pr * ps + $urandom_range(2);
					rmax  = $urandom_range(rmin + ps, rows + 2);
					thr   = $urandom_range(ps * ps * amax);
					cells = cols * rows;
					if ($urandom_range(3) == 0)
						cells = cells * $urandom_range(60, 100) / 100;
					if (cells > MAX_CELLS)
						cells = MAX_CELLS;
					// keep the old position so the new settings land mid-frame
					if (kind == PH_CONTINUE)
						with_start = 1'b0;
				end
				PH_OVERRUN: begin
					cols       = $urandom_range(1, 2);
					rmin       = $urandom_range(1) ? $urandom_range(100, 127) : 0;
					rmax       = $urandom_range(120, 255);
					ps         = 1;
					thr        = $urandom_range(4094);
					restart_at = cols * 128 + $urandom_range(2, 6);
					cells      = restart_at + 3;
				end
				PH_EXTREME: begin
					cols  = $urandom_range(1) ? col_ext[$urandom_range(3)] : $urandom_range(2, 12);
					rmin  = $urandom_range(1) ? rmin_ext[$urandom_range(1)] : $urandom_range(3);
					rmax  = $urandom_range(1) ? rmax_ext[$urandom_range(2)] : $urandom_range(4, 24);
					ps    = $urandom_range(1) ? ps_ext[$urandom_range(3)] : $urandom_range(1, 4);
					thr   = $urandom_range(1) ? thr_ext[$urandom_range(1)] : $urandom_range(20000);
					mask  = $urandom_range(1) ? mask_ext[$urandom_range(1)] : $urandom;
					ec    = (cols < 1) ? 1 : (cols > 64) ? 64 : cols;
					cells = ec * $urandom_range(3, 20);
					if (cells > MAX_CELLS)
						cells = MAX_CELLS;
				end
				default: begin
					cols       = $urandom_range(127);
					rmin       = $urandom_range(7);
					rmax       = $urandom_range(255);
					ps         = $urandom_range(31);
					thr        = $urandom_range(30000);
					fs_pct     = 10;
					with_start = $urandom_range(1);
					cells      = $urandom_range(40, 150);
				end
			endcase
			// the last phase stops at the item budget
			if (cells > target - n_sent)
				cells = target - n_sent;

			apply_config(cols, rmin, rmax, ps, thr, mask, phase_no == 2);

			for (int k = 0; k < cells; k++) begin
				case (adc_mode)
					MIX_FULL: adc = $urandom_range(4095);
					MIX_MAX:  adc = 4095;
					MIX_LOW:  adc = $urandom_range(15);
					default: begin
						r   = $urandom_range(2);
						adc = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(4095);
					end
				endcase
				fs = (k == 0 && with_start) || (k == restart_at) || ($urandom_range(99) < fs_pct);
				send_cell(adc, fs);
			end
			phase_no++;
		end

		// drain and let the pipeline settle
		cell_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d predicted reports never arrived", $time, sb.pending());
			sb.errors += sb.pending();
		end

		$display("Streamed %0d cells under %0d register settings, incl. grid overrun,",
			sb.cells_seen, n_settings);
		$display("clamped registers and mid-frame changes; %0d reports compared, %0d mismatches",
			sb.patches_seen, sb.errors);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
